@@ hw/rtl/lfu_pkg.sv @@
// shared types and constants for the lfu cache table
package lfu_pkg;

	// default geometry
	localparam int ENTRIES_DEF    = 16;
	localparam int COUNT_BITS_DEF = 16;

	// capacity register
	localparam int             CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// transaction kinds
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_SET = 1'b1;

	// request transaction
	typedef struct packed {
		logic               kind;
		logic signed [31:0] lookup_key;
		logic signed [31:0] write_value;
	} req_t;

	// response transaction
	typedef struct packed {
		logic               found;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} rsp_t;

endpackage

@@ hw/rtl/lfu_victim_sel.sv @@
// replacement victim select: lowest use count, oldest among equal counts
module lfu_victim_sel #(
	parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
	parameter int RANK_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic [ENTRIES-1:0]                 valid,
	input  logic [ENTRIES-1:0][COUNT_BITS-1:0] use_count,
	input  logic [ENTRIES-1:0][RANK_W-1:0]     rank,
	output logic [ENTRIES-1:0]                 victim
);

	// pairwise compare matrix; ranks are unique among valid slots so one slot wins
	always_comb begin
		logic beats;
		for (int i = 0; i < ENTRIES; i++) begin
			beats = valid[i];
			for (int j = 0; j < ENTRIES; j++) begin
				if (j != i && valid[j]) begin
					if (!((use_count[i] < use_count[j]) ||
					      (use_count[i] == use_count[j] && rank[i] > rank[j]))) begin
						beats = 1'b0;
					end
				end
			end
			victim[i] = beats;
		end
	end

endmodule

@@ hw/rtl/lfu_cache_table.sv @@
// lfu cache table top level: request/response channels, slot store and update logic
//
// Fully associative key/value cache with least-frequently-used replacement,
// least-recently-used among equal use counts.
// Request channel (req_valid/req_ready/req) carries a get or a set transaction;
// response channel (rsp_valid/rsp_ready/rsp) returns one transaction per request
// with hit flag, read value and any evicted key.
// cfg_we/cfg_wdata write the capacity register; write it only while idle.
// An accepted request is held in the request register, and its response is written to
// the response register when the response side does not stall. Throughput: one
// transaction per cycle while the response side does not stall; the key compare,
// victim select and slot update are combinational between the two registers.
// Reset clears all slot valid bits, the occupancy count and sets capacity to 16;
// key, value, count and rank storage hold garbage until written.
// When the receiver stalls, the finished response holds in its register and one
// further request is taken into the request register; then req_ready drops.
module lfu_cache_table #(
	parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  lfu_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output lfu_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int CW     = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;

	// request stage and response register
	logic          valid_s1;
	lfu_pkg::req_t req_s1;
	logic          rsp_valid_q;
	lfu_pkg::rsp_t rsp_q;
	logic          adv;

	// slot store
	logic [ENTRIES-1:0]                 valid_q;
	logic [ENTRIES-1:0][31:0]           key_q;
	logic [ENTRIES-1:0][31:0]           value_q;
	logic [ENTRIES-1:0][COUNT_BITS-1:0] count_q;
	logic [ENTRIES-1:0][RANK_W-1:0]     rank_q;
	logic [OCC_W-1:0]                   occ_q;
	logic [lfu_pkg::CAP_W-1:0]          cap_q;

	// decision signals
	logic [ENTRIES-1:0] hit_oh;
	logic [ENTRIES-1:0] vic_oh;
	logic [ENTRIES-1:0] avail;
	logic [ENTRIES-1:0] free_oh;
	logic               hit;
	logic [RANK_W-1:0]  hit_rank;
	logic [RANK_W-1:0]  vic_rank;
	logic [31:0]        hit_value;
	logic [31:0]        vic_key;
	logic [CW-1:0]      cap_eff;
	logic               is_set;
	logic               set_on;
	logic               do_touch;
	logic               do_insert;
	logic               do_evict;

	// handshake
	assign adv       = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// victim search
	lfu_victim_sel #(
		.ENTRIES   (ENTRIES),
		.COUNT_BITS(COUNT_BITS),
		.RANK_W    (RANK_W)
	) u_victim (
		.valid    (valid_q),
		.use_count(count_q),
		.rank     (rank_q),
		.victim   (vic_oh)
	);

	// key match and one-hot selects
	always_comb begin
		hit_rank  = '0;
		vic_rank  = '0;
		hit_value = '0;
		vic_key   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_oh[i] = valid_q[i] && (key_q[i] == req_s1.lookup_key);
		end
		for (int i = 0; i < ENTRIES; i++) begin
			hit_rank  = hit_rank  | (rank_q[i]  & {RANK_W{hit_oh[i]}});
			hit_value = hit_value | (value_q[i] & {32{hit_oh[i]}});
			vic_rank  = vic_rank  | (rank_q[i]  & {RANK_W{vic_oh[i]}});
			vic_key   = vic_key   | (key_q[i]   & {32{vic_oh[i]}});
		end
		hit = |hit_oh;
	end

	// operation decode
	always_comb begin
		cap_eff   = (CW'(cap_q) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_q);
		is_set    = (req_s1.kind == lfu_pkg::KIND_SET);
		set_on    = is_set && (cap_eff != '0);
		do_touch  = hit && (!is_set || set_on);
		do_insert = set_on && !hit;
		do_evict  = do_insert && (CW'(occ_q) >= cap_eff) && (|valid_q);
		avail     = ~valid_q | (vic_oh & {ENTRIES{do_evict}});
		free_oh   = avail & (~avail + ENTRIES'(1));
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.found       <= do_touch;
			rsp_q.read_value  <= (!is_set && hit) ? hit_value : '0;
			rsp_q.evicted     <= do_evict;
			rsp_q.evicted_key <= do_evict ? vic_key : '0;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (adv && do_insert) begin
			valid_q <= (valid_q & ~(vic_oh & {ENTRIES{do_evict}})) | free_oh;
			if (!do_evict) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	// slot payload: key, value, use count, recency rank
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_touch) begin
					if (hit_oh[i]) begin
						rank_q[i] <= '0;
						if (count_q[i] != '1) begin
							count_q[i] <= count_q[i] + COUNT_BITS'(1);
						end
						if (is_set) begin
							value_q[i] <= req_s1.write_value;
						end
					end else if (valid_q[i] && rank_q[i] < hit_rank) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end else if (do_insert) begin
					if (free_oh[i]) begin
						rank_q[i]  <= '0;
						count_q[i] <= COUNT_BITS'(1);
						key_q[i]   <= req_s1.lookup_key;
						value_q[i] <= req_s1.write_value;
					end else if (valid_q[i] && !(do_evict && vic_oh[i])) begin
						if (!(do_evict && rank_q[i] > vic_rank)) begin
							rank_q[i] <= rank_q[i] + RANK_W'(1);
						end
					end
				end
			end
		end
	end

endmodule

@@ hw/rtl/lfu_cache_table_chk.sv @@
// port checker for the lfu cache table, bound to the top level
module lfu_cache_table_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input lfu_pkg::rsp_t rsp
);

	// a stalled response transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// evicted key is zero unless an eviction happened
	a_evk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.evicted |-> rsp.evicted_key == '0)
		else $error("evicted key without eviction");

	// read value is zero on a miss
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.read_value == '0)
		else $error("read value on a miss");

	// an eviction only comes from a set that missed
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evicted |-> !rsp.found && rsp.read_value == '0)
		else $error("eviction on a hit");

endmodule

bind lfu_cache_table lfu_cache_table_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
